// File: rtl/sscs_pkg.sv
// sscs_pkg: shared types and constants of the spindle socket clamp supervisor
// no dependencies; imported by every module of the block
package sscs_pkg;

    localparam int CFG_DATA_W   = 15;
    localparam int TIMEOUT_W    = 15;
    localparam int TARGET_W     = 10;
    localparam int MS_W         = 16;
    localparam int PULSE_W      = 11;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 15'd5000;
    localparam logic [TARGET_W-1:0]  PULSE_TARGET_RST = 10'd10;
    localparam logic                 USE_FB_RST      = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK          = 2'd0,
        OP_START_UNCLAMP = 2'd1,
        OP_START_CLAMP   = 2'd2,
        OP_NONE          = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_SUCCESS     = 2'd0,
        RES_ALARM_START = 2'd1,
        RES_ALARM_RUN   = 2'd2,
        RES_TIMEOUT     = 2'd3
    } res_code_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT      = 2'd0,
        CFG_PULSE_TARGET = 2'd1,
        CFG_USE_FEEDBACK = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_limit_ms;
        logic [TARGET_W-1:0]  pulse_target;
        logic                 use_feedback;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        logic alarm;
        logic fg_pulse;
    } item_t;

    typedef struct packed {
        logic                spindle_run;
        logic                spindle_reverse;
        logic                busy_res;
        logic                done_res;
        res_code_t           result_code;
        logic [PULSE_W-1:0]  pulse_total;
    } result_t;

endpackage

// File: rtl/sscs_cfg.sv
// sscs_cfg: configuration register file of the clamp supervisor
// depends on sscs_pkg
module sscs_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [sscs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sscs_pkg::cfg_t                   cfg
);
    import sscs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit_ms <= TIMEOUT_RST;
            cfg_reg.pulse_target     <= PULSE_TARGET_RST;
            cfg_reg.use_feedback     <= USE_FB_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:      cfg_reg.timeout_limit_ms <= cfg_data[TIMEOUT_W-1:0];
                CFG_PULSE_TARGET: cfg_reg.pulse_target     <= cfg_data[TARGET_W-1:0];
                CFG_USE_FEEDBACK: cfg_reg.use_feedback     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/sscs_core.sv
// sscs_core: run state registers and per-beat supervision logic
// depends on sscs_pkg; result is combinational from the held item and state
module sscs_core #(
    parameter int POLL_TICKS = 10,
    parameter int RAMP_TICKS = 200,
    parameter int IDLE_LIMIT = 300,
    parameter int MIN_PULSES = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sscs_pkg::item_t   item,
    input  sscs_pkg::cfg_t    cfg,
    output sscs_pkg::result_t res
);
    import sscs_pkg::*;

    localparam int PW = $clog2(POLL_TICKS + 1);
    localparam logic [PW-1:0]      POLL_LAST = PW'(POLL_TICKS);
    localparam logic [MS_W-1:0]    RAMP_MS   = MS_W'(RAMP_TICKS);
    localparam logic [MS_W-1:0]    IDLE_MS   = MS_W'(IDLE_LIMIT);
    localparam logic [PULSE_W-1:0] MIN_CNT   = PULSE_W'(MIN_PULSES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RAMP,
        PH_POLL,
        PH_WAIT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               is_clamp_reg, is_clamp_next;
    logic [MS_W-1:0]    elapsed_reg, elapsed_next;
    logic [MS_W-1:0]    idle_reg, idle_next;
    logic [PW-1:0]      poll_reg, poll_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic               done;
    res_code_t          code;
    logic [PW-1:0]      poll_inc;
    logic [MS_W-1:0]    run_limit;

    assign poll_inc  = poll_reg + PW'(1);
    assign run_limit = {1'b0, cfg.timeout_limit_ms};

    always_comb
    begin
        phase_next    = phase_reg;
        is_clamp_next = is_clamp_reg;
        elapsed_next  = elapsed_reg;
        idle_next     = idle_reg;
        poll_next     = poll_reg;
        pulse_next    = pulse_reg;
        done          = 1'b0;
        code          = RES_SUCCESS;
        if (item.op == OP_START_UNCLAMP || item.op == OP_START_CLAMP)
        begin
            if (phase_reg == PH_IDLE)
            begin
                is_clamp_next = (item.op == OP_START_CLAMP);
                elapsed_next  = '0;
                idle_next     = '0;
                poll_next     = '0;
                pulse_next    = '0;
                if (item.alarm)
                begin
                    done = 1'b1;
                    code = RES_ALARM_START;
                end
                else if (!cfg.use_feedback)
                    phase_next = PH_WAIT;
                else if (is_clamp_next && RAMP_TICKS > 0)
                    phase_next = PH_RAMP;
                else
                    phase_next = PH_POLL;
            end
        end
        else if (item.op == OP_TICK && phase_reg != PH_IDLE)
        begin
            // saturating time and pulse bookkeeping, all phases
            if (elapsed_reg != '1)
                elapsed_next = elapsed_reg + MS_W'(1);
            if (item.fg_pulse)
            begin
                idle_next = '0;
                if (pulse_reg != '1)
                    pulse_next = pulse_reg + PULSE_W'(1);
            end
            else if (idle_reg != '1)
                idle_next = idle_reg + MS_W'(1);

            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (elapsed_next >= run_limit)
                    begin
                        done       = 1'b1;
                        code       = item.alarm ? RES_ALARM_RUN : RES_SUCCESS;
                        phase_next = PH_IDLE;
                    end
                end
                PH_RAMP:
                begin
                    if (elapsed_next >= RAMP_MS)
                    begin
                        phase_next = PH_POLL;
                        poll_next  = '0;
                    end
                end
                PH_POLL:
                begin
                    if (poll_inc < POLL_LAST)
                        poll_next = poll_inc;
                    else
                    begin
                        poll_next = '0;
                        // alarm first, then success, then timeout
                        priority if (item.alarm)
                        begin
                            done = 1'b1;
                            code = RES_ALARM_RUN;
                        end
                        else if (is_clamp_reg && idle_next > IDLE_MS
                                 && pulse_next > MIN_CNT)
                            done = 1'b1;
                        else if (!is_clamp_reg
                                 && pulse_next >= PULSE_W'(cfg.pulse_target))
                            done = 1'b1;
                        else if (elapsed_next > run_limit)
                        begin
                            done = 1'b1;
                            code = RES_TIMEOUT;
                        end
                        else
                            done = 1'b0;
                        if (done)
                            phase_next = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_clamp_reg <= 1'b0;
            elapsed_reg  <= '0;
            idle_reg     <= '0;
            poll_reg     <= '0;
            pulse_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            is_clamp_reg <= is_clamp_next;
            elapsed_reg  <= elapsed_next;
            idle_reg     <= idle_next;
            poll_reg     <= poll_next;
            pulse_reg    <= pulse_next;
        end
    end

    always_comb
    begin
        res.busy_res        = (phase_next != PH_IDLE);
        res.spindle_run     = (phase_next != PH_IDLE);
        res.spindle_reverse = (phase_next != PH_IDLE) && !is_clamp_next;
        res.done_res        = done;
        res.result_code     = code;
        res.pulse_total     = pulse_next;
    end

    // a finished run leaves the block idle
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> phase_reg == PH_IDLE)
        else $error("run finished but phase not idle");

    // pulse count only drops when a new run starts
    a_pulse_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_TICK |=> pulse_reg >= $past(pulse_reg))
        else $error("pulse count decreased on a tick");

    // the poll divider never reaches its terminal count
    a_poll_range: assert property (@(posedge clk) disable iff (!rst_n)
        poll_reg < POLL_LAST)
        else $error("poll counter out of range");

    // a start while busy leaves the run settings alone
    a_start_busy_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg != PH_IDLE
        && (item.op == OP_START_UNCLAMP || item.op == OP_START_CLAMP)
        |=> $stable(is_clamp_reg) && $stable(elapsed_reg))
        else $error("start accepted during a run");

endmodule

// File: rtl/spindle_socket_clamp_supervisor.sv
// spindle_socket_clamp_supervisor: a beat passes the input register, then the result
// register; one beat accepted per cycle sustained while out_stall is low.
// a beat waiting in the result register stalls a full input register; one more beat is taken.
// rst_n (async, active low) empties both registers, sets the run state to idle
// and loads register defaults: timeout 5000 ms, pulse target 10, feedback on.
// depends on sscs_pkg, sscs_cfg, sscs_core
module spindle_socket_clamp_supervisor #(
    parameter int POLL_TICKS = 10,
    parameter int RAMP_TICKS = 200,
    parameter int IDLE_LIMIT = 300,
    parameter int MIN_PULSES = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [sscs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic                             alarm,
    input  logic                             fg_pulse,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             spindle_run,
    output logic                             spindle_reverse,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [1:0]                       result_code,
    output logic [sscs_pkg::PULSE_W-1:0]     pulse_total
);
    import sscs_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t res;
    result_t res_reg;
    logic    fire;
    logic    in_take;

    // item moves into the result register when that slot is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    sscs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sscs_core #(
        .POLL_TICKS (POLL_TICKS),
        .RAMP_TICKS (RAMP_TICKS),
        .IDLE_LIMIT (IDLE_LIMIT),
        .MIN_PULSES (MIN_PULSES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op       <= op_t'(op);
            item_reg.alarm    <= alarm;
            item_reg.fg_pulse <= fg_pulse;
        end
        if (fire)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign spindle_run     = res_reg.spindle_run;
    assign spindle_reverse = res_reg.spindle_reverse;
    assign busy_res        = res_reg.busy_res;
    assign done_res        = res_reg.done_res;
    assign result_code     = res_reg.result_code;
    assign pulse_total     = res_reg.pulse_total;

endmodule

// File: dv/tb.sv
// tb: self-checking bench for spindle_socket_clamp_supervisor, runs directed and random beats
// holds its own run predictor in a small scoreboard class; depends on sscs_pkg and the rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sscs_pkg::*;

    localparam int POLL_TICKS    = 10;
    localparam int RAMP_TICKS    = 200;
    localparam int IDLE_LIMIT    = 300;
    localparam int MIN_PULSES    = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;

    class clamp_run_checker;
        typedef enum logic [1:0] {RUN_IDLE, RUN_RAMP, RUN_POLL, RUN_TIMED} run_phase_t;

        logic [TIMEOUT_W-1:0] limit_ms;
        logic [TARGET_W-1:0]  target;
        logic                 feedback;
        run_phase_t           phase;
        logic                 clamping;
        logic [MS_W-1:0]      elapsed;
        logic [7:0]           poll;
        logic [PULSE_W-1:0]   pulses;
        logic [MS_W-1:0]      quiet_ms;
        result_t              due_results[$];
        int                   errors;
        int                   results_seen;
        int                   endings[4];

        function new();
            limit_ms     = TIMEOUT_RST;
            target       = PULSE_TARGET_RST;
            feedback     = USE_FB_RST;
            phase        = RUN_IDLE;
            clamping     = 1'b0;
            elapsed      = '0;
            poll         = '0;
            pulses       = '0;
            quiet_ms     = '0;
            errors       = 0;
            results_seen = 0;
            foreach (endings[i])
                endings[i] = 0;
        endfunction

        function void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TIMEOUT:      limit_ms = v[TIMEOUT_W-1:0];
                CFG_PULSE_TARGET: target   = v[TARGET_W-1:0];
                CFG_USE_FEEDBACK: feedback = v[0];
                default: ;
            endcase
        endfunction

        function result_t outcome(logic done, res_code_t code);
            result_t r;
            r.spindle_run     = phase != RUN_IDLE;
            r.spindle_reverse = phase != RUN_IDLE && !clamping;
            r.busy_res        = phase != RUN_IDLE;
            r.done_res        = done;
            r.result_code     = done ? code : RES_SUCCESS;
            r.pulse_total     = pulses;
            if (done)
                endings[int'(code)]++;
            return r;
        endfunction

        function result_t end_run(res_code_t code);
            phase = RUN_IDLE;
            return outcome(1'b1, code);
        endfunction

        function result_t advance_run(op_t o, logic a, logic p);
            if (o == OP_START_UNCLAMP || o == OP_START_CLAMP)
            begin
                // a start during a run is dropped
                if (phase != RUN_IDLE)
                    return outcome(1'b0, RES_SUCCESS);
                clamping = (o == OP_START_CLAMP);
                elapsed  = '0;
                poll     = '0;
                pulses   = '0;
                quiet_ms = '0;
                if (a)
                    return end_run(RES_ALARM_START);
                if (!feedback)
                    phase = RUN_TIMED;
                else if (clamping && RAMP_TICKS > 0)
                    phase = RUN_RAMP;
                else
                    phase = RUN_POLL;
                return outcome(1'b0, RES_SUCCESS);
            end
            if (o != OP_TICK || phase == RUN_IDLE)
                return outcome(1'b0, RES_SUCCESS);

            if (elapsed != '1)
                elapsed++;
            if (p)
            begin
                quiet_ms = '0;
                if (pulses != '1)
                    pulses++;
            end
            else if (quiet_ms != '1)
            begin
                quiet_ms++;
            end

            if (phase == RUN_TIMED)
            begin
                if (elapsed >= limit_ms)
                    return end_run(a ? RES_ALARM_RUN : RES_SUCCESS);
                return outcome(1'b0, RES_SUCCESS);
            end
            // alarm is not looked at while the clamp ramps up
            if (phase == RUN_RAMP)
            begin
                if (elapsed >= RAMP_TICKS)
                begin
                    phase = RUN_POLL;
                    poll  = '0;
                end
                return outcome(1'b0, RES_SUCCESS);
            end

            poll++;
            if (poll < POLL_TICKS)
                return outcome(1'b0, RES_SUCCESS);
            poll = '0;
            if (a)
                return end_run(RES_ALARM_RUN);
            if (clamping)
            begin
                if (quiet_ms > IDLE_LIMIT && pulses > MIN_PULSES)
                    return end_run(RES_SUCCESS);
            end
            else if (pulses >= target)
            begin
                return end_run(RES_SUCCESS);
            end
            if (elapsed > limit_ms)
                return end_run(RES_TIMEOUT);
            return outcome(1'b0, RES_SUCCESS);
        endfunction

        function void take_command(logic [1:0] op_bits, logic a, logic p);
            due_results.push_back(advance_run(op_t'(op_bits), a, p));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("tb: mismatch: %s", msg);
        endtask

        task check_field(string name, logic [PULSE_W-1:0] got, logic [PULSE_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
        endtask

        task match_result(result_t got);
            result_t want;
            results_seen++;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing due", results_seen));
                return;
            end
            want = due_results.pop_front();
            check_field("spindle_run", PULSE_W'(got.spindle_run),
                        PULSE_W'(want.spindle_run));
            check_field("spindle_reverse", PULSE_W'(got.spindle_reverse),
                        PULSE_W'(want.spindle_reverse));
            check_field("busy_res", PULSE_W'(got.busy_res), PULSE_W'(want.busy_res));
            check_field("done_res", PULSE_W'(got.done_res), PULSE_W'(want.done_res));
            check_field("result_code", PULSE_W'(got.result_code),
                        PULSE_W'(want.result_code));
            check_field("pulse_total", got.pulse_total, want.pulse_total);
        endtask

        task close_out();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            op;
    logic                  alarm;
    logic                  fg_pulse;
    logic                  out_valid;
    logic                  out_stall;
    logic                  spindle_run;
    logic                  spindle_reverse;
    logic                  busy_res;
    logic                  done_res;
    logic [1:0]            result_code;
    logic [PULSE_W-1:0]    pulse_total;

    clamp_run_checker sb;
    result_t          seen_result;
    bit               gaps_on = 1'b1;
    int               beats_sent = 0;
    int               random_left;

    spindle_socket_clamp_supervisor #(
        .POLL_TICKS (POLL_TICKS),
        .RAMP_TICKS (RAMP_TICKS),
        .IDLE_LIMIT (IDLE_LIMIT),
        .MIN_PULSES (MIN_PULSES)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .alarm           (alarm),
        .fg_pulse        (fg_pulse),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .spindle_run     (spindle_run),
        .spindle_reverse (spindle_reverse),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .result_code     (result_code),
        .pulse_total     (pulse_total)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // both beats are taken from pre-edge values
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.take_command(op, alarm, fg_pulse);
            if (out_valid && !out_stall)
            begin
                seen_result.spindle_run     = spindle_run;
                seen_result.spindle_reverse = spindle_reverse;
                seen_result.busy_res        = busy_res;
                seen_result.done_res        = done_res;
                seen_result.result_code     = res_code_t'(result_code);
                seen_result.pulse_total     = pulse_total;
                sb.match_result(seen_result);
            end
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(input op_t o, input logic a, input logic p);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        alarm    <= a;
        fg_pulse <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.results_seen < beats_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [TIMEOUT_W-1:0] lim, input logic [TARGET_W-1:0] tgt,
                              input logic fb);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_index <= CFG_PULSE_TARGET;
        cfg_data  <= CFG_DATA_W'(tgt);
        @(posedge clk);
        cfg_index <= CFG_USE_FEEDBACK;
        cfg_data  <= CFG_DATA_W'(fb);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.load_reg(CFG_TIMEOUT, CFG_DATA_W'(lim));
        sb.load_reg(CFG_PULSE_TARGET, CFG_DATA_W'(tgt));
        sb.load_reg(CFG_USE_FEEDBACK, CFG_DATA_W'(fb));
    endtask

    // one start followed by a tick stream, with occasional random beats, and a shaped pulse and alarm profile
    task automatic drive_run();
        op_t  start_op;
        int   len;
        int   pulse_span;
        int   density;
        int   alarm_odds;
        logic a;
        logic p;
        start_op = $urandom_range(0, 1) ? OP_START_CLAMP : OP_START_UNCLAMP;
        send_beat(start_op, $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
        random_left--;
        if ($urandom_range(0, 7) == 0)
        begin
            len        = $urandom_range(250, 420);
            pulse_span = $urandom_range(0, 60);
        end
        else
        begin
            len        = $urandom_range(1, 60);
            pulse_span = $urandom_range(0, len);
        end
        density = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
            2:       alarm_odds = 400;
            3:       alarm_odds = 30;
            default: alarm_odds = 0;
        endcase
        for (int k = 0; k < len && random_left > 0; k++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_beat(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                p = k < pulse_span && $urandom_range(1, 4) <= density;
                a = alarm_odds != 0 && $urandom_range(1, alarm_odds) == 1;
                send_beat(OP_TICK, a, p);
            end
            random_left--;
        end
    endtask

    initial
    begin
        int settle_wait;
        in_valid  <= 1'b0;
        op        <= OP_TICK;
        alarm     <= 1'b0;
        fg_pulse  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: idle noise, alarm at start, start while busy, unclamp by pulses
        send_beat(OP_TICK, 1'b0, 1'b0);
        send_beat(OP_TICK, 1'b1, 1'b1);
        send_beat(OP_NONE, 1'b1, 1'b1);
        send_beat(OP_NONE, 1'b0, 1'b0);
        send_beat(OP_START_UNCLAMP, 1'b1, 1'b0);
        send_beat(OP_START_CLAMP, 1'b1, 1'b1);
        send_beat(OP_START_UNCLAMP, 1'b0, 1'b0);
        send_beat(OP_START_CLAMP, 1'b1, 1'b1);
        send_beat(OP_NONE, 1'b1, 1'b1);
        send_beat(OP_START_UNCLAMP, 1'b0, 1'b0);
        repeat (10) send_beat(OP_TICK, 1'b0, 1'b1);
        drain();

        // timed mode with a zero limit ends on the first tick
        set_config(15'd0, 10'd0, 1'b0);
        send_beat(OP_START_CLAMP, 1'b0, 1'b0);
        send_beat(OP_TICK, 1'b1, 1'b1);
        send_beat(OP_START_UNCLAMP, 1'b0, 1'b0);
        send_beat(OP_TICK, 1'b0, 1'b0);
        drain();

        // zero pulse target passes on the first check
        set_config(15'd100, 10'd0, 1'b1);
        send_beat(OP_START_UNCLAMP, 1'b0, 1'b0);
        repeat (10) send_beat(OP_TICK, 1'b0, 1'b0);
        drain();

        // alarms during the ramp are ignored, then the first check times out
        set_config(15'd100, 10'd1, 1'b1);
        send_beat(OP_START_CLAMP, 1'b0, 1'b0);
        for (int k = 0; k < 210; k++)
            send_beat(OP_TICK, k < 200 && ($urandom_range(0, 1) || k == 199), 1'b0);
        drain();

        // pulses counted on an unclamp short of its target, then an alarm ends it
        set_config(15'd30000, 10'd1000, 1'b1);
        send_beat(OP_START_UNCLAMP, 1'b0, 1'b0);
        repeat (30) send_beat(OP_TICK, 1'b0, 1'b1);
        repeat (10) send_beat(OP_TICK, 1'b1, 1'b0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(15'd100, 10'd1, 1'b1);
                1: set_config(15'd30000, 10'd1000, 1'b1);
                2: set_config(15'h7fff, 10'h3ff, 1'b0);
                default:
                    set_config(TIMEOUT_W'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(400, 6000)
                                          : $urandom_range(0, 80)),
                               TARGET_W'($urandom_range(0, 20)), $urandom_range(0, 2) != 0);
            endcase
            if (ph == RANDOM_PHASES - 1)
                gaps_on = 1'b0;
            random_left = (ph == 2) ? 60 : 220;
            if (ph == 3)
            begin
                // hold off mid-phase until every result is back
                while (random_left > 110)
                    drive_run();
                drain();
            end
            while (random_left > 0)
                drive_run();
            drain();
        end

        settle_wait = 0;
        while (sb.results_seen < beats_sent && settle_wait < 20000)
        begin
            @(posedge clk);
            settle_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.close_out();

        $display("tb: %0d command beats sent, %0d result beats checked", beats_sent,
                 sb.results_seen);
        $display("tb: runs ended ok %0d, alarm at start %0d, alarm in run %0d, timeout %0d",
                 sb.endings[0], sb.endings[1], sb.endings[2], sb.endings[3]);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
rtl/sscs_pkg.sv
rtl/sscs_cfg.sv
rtl/sscs_core.sv
rtl/spindle_socket_clamp_supervisor.sv
dv/tb.sv
